// ===== design/bpa_pkg.sv =====
// shared types and constants for the buddy page allocator
package bpa_pkg;

  localparam int NUM_PAGES = 4096;
  localparam int MAX_ORDER = 11;
  localparam int IDX_W     = $clog2(NUM_PAGES);
  localparam int LVL_W     = 4;
  localparam int CNT_W     = 13;
  localparam int TOT_W     = 24;
  localparam int PFN_W     = 20;
  localparam int FRAME_W   = 21;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [LVL_W-1:0] lvl_t;

  // one word of the page memory
  typedef struct packed {
    lvl_t ord;
    logic used;
    logic fhead;
    idx_t nxt;
    idx_t prv;
  } page_word_t;

  localparam int WORD_W = $bits(page_word_t);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_ORDER = 2'd1,
    ST_NO_MEM    = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_FIRST_FRAME = 2'd0,
    REG_PAGE_COUNT  = 2'd1
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_A_START,
    S_A_UNL,
    S_A_LOOP,
    S_A_FIN,
    S_F_START,
    S_F_HEAD,
    S_F_CHK,
    S_F_BUD,
    S_U_PRD,
    S_U_PWR,
    S_U_NWR,
    S_F_ORD_RD,
    S_F_ORD_WR,
    S_PU_WR,
    S_PU_TW,
    S_OUT
  } fsm_t;

  // list update request towards the free list registers
  typedef struct packed {
    logic inc;
    logic dec;
    lvl_t lvl;
    logic wr_head;
    idx_t head_val;
    logic wr_tail;
    idx_t tail_val;
    logic set_full;
    logic clr_full;
  } lst_cmd_t;

  typedef struct packed {
    idx_t                 head;
    idx_t                 tail;
    logic                 full;
    logic [MAX_ORDER-1:0] full_mask;
    logic [CNT_W-1:0]     free_pages;
  } lst_stat_t;

endpackage

// ===== design/buddy_page_allocator.sv =====
// buddy page allocator top level: register port, request sequencer, page memory
// an allocate splits the found block down level by level, a free merges with each free buddy
// level by level, and rejected or ignored requests go to the result without a list change
// one request at a time: the next one can be taken in the cycle after the result transfer
// reset: a clearing pass writes all 4096 page entries before the first request
module buddy_page_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [3:0]  order,
  input  logic [19:0] pfn,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [20:0] frame,
  output logic [12:0] free_pages
);
  import bpa_pkg::*;

  fsm_t       state, state_next;
  logic [PFN_W-1:0] first_frame;
  logic [CNT_W-1:0] page_count;
  logic       act_q;
  lvl_t       ord_q;
  logic [PFN_W-1:0] pfn_q;
  idx_t       node, aux, aux2, clr_cnt;
  lvl_t       lvl, req;
  logic       is_free;
  status_t    status_q;
  logic [FRAME_W-1:0] frame_q;

  logic       we;
  idx_t       waddr, raddr;
  page_word_t wword, d;
  logic [WORD_W-1:0] rdata;
  lst_cmd_t   cmd;
  lst_stat_t  stat;

  reg_idx_t   reg_sel;
  logic       cfg_wr;
  logic [CNT_W-1:0] lim;
  logic [PFN_W-1:0] pfn_off;
  logic       in_range;
  logic [MAX_ORDER-1:0] cand;
  logic       found;
  lvl_t       found_lvl;
  idx_t       bud, up_mask;
  logic       head_bad, chk_stop, bud_match, bud_mid;
  lvl_t       lvl_up;

  bpa_page_ram #(.DEPTH(NUM_PAGES), .WIDTH(WORD_W)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wword), .raddr(raddr), .rdata(rdata)
  );

  bpa_free_lists u_lists (.clk(clk), .rst(rst), .cmd(cmd), .stat(stat));

  assign d = page_word_t'(rdata);

  // register port
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'({1'b0, paddr[2]});
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_frame <= '0;
      page_count  <= CNT_W'(NUM_PAGES);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_FIRST_FRAME: first_frame <= pwdata[PFN_W-1:0];
        REG_PAGE_COUNT:  page_count  <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FIRST_FRAME: prdata = {{(32-PFN_W){1'b0}}, first_frame};
      REG_PAGE_COUNT:  prdata = {{(32-CNT_W){1'b0}}, page_count};
      default:         prdata = '0;
    endcase
  end

  // decision logic
  always_comb begin
    lim      = (page_count > CNT_W'(NUM_PAGES)) ? CNT_W'(NUM_PAGES) : page_count;
    pfn_off  = pfn_q - first_frame;
    in_range = (pfn_q >= first_frame) && (pfn_off < PFN_W'(lim));
    cand     = stat.full_mask & ({MAX_ORDER{1'b1}} << ord_q);
    found    = |cand;
    found_lvl = '0;
    for (int o = MAX_ORDER - 1; o >= 0; o--) begin
      if (cand[o]) found_lvl = LVL_W'(o);
    end
    bud      = node ^ (idx_t'(1) << lvl);
    lvl_up   = lvl + 1'b1;
    up_mask  = (idx_t'(1) << lvl_up) - 1'b1;
    head_bad = (d.ord >= LVL_W'(MAX_ORDER)) ||
               ((node & ((idx_t'(1) << d.ord) - 1'b1)) != '0);
    chk_stop = (lvl >= LVL_W'(MAX_ORDER - 1)) || ({1'b0, bud} >= lim);
    bud_match = (d.ord == lvl) && d.fhead;
    bud_mid  = stat.full && (stat.head != bud) && (stat.tail != bud);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:    if (clr_cnt == {IDX_W{1'b1}}) state_next = S_IDLE;
      S_IDLE:     if (in_valid) state_next = action ? S_F_START : S_A_START;
      S_A_START:  state_next = (ord_q < LVL_W'(MAX_ORDER) && found) ? S_A_UNL : S_OUT;
      S_A_UNL:    state_next = S_A_LOOP;
      S_A_LOOP:   state_next = (lvl > req) ? S_PU_WR : S_A_FIN;
      S_A_FIN:    state_next = S_OUT;
      S_F_START:  state_next = in_range ? S_F_HEAD : S_OUT;
      S_F_HEAD:   state_next = (head_bad || !d.used) ? S_OUT : S_F_CHK;
      S_F_CHK:    state_next = chk_stop ? S_PU_WR : S_F_BUD;
      S_F_BUD: begin
        if (!bud_match) state_next = S_PU_WR;
        else if (bud_mid) state_next = S_U_PRD;
        else state_next = S_F_ORD_RD;
      end
      S_U_PRD:    state_next = S_U_PWR;
      S_U_PWR:    state_next = S_U_NWR;
      S_U_NWR:    state_next = S_F_ORD_RD;
      S_F_ORD_RD: state_next = S_F_ORD_WR;
      S_F_ORD_WR: state_next = S_F_CHK;
      S_PU_WR: begin
        if (stat.full) state_next = S_PU_TW;
        else state_next = is_free ? S_OUT : S_A_LOOP;
      end
      S_PU_TW:    state_next = is_free ? S_OUT : S_A_LOOP;
      S_OUT:      if (out_ready) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // memory and list control
  always_comb begin
    we       = 1'b0;
    waddr    = node;
    wword    = d;
    raddr    = node;
    cmd      = '0;
    cmd.lvl  = lvl;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt;
        wword = '{ord: '0, used: 1'b1, fhead: 1'b0, nxt: '0, prv: '0};
      end
      S_IDLE: in_ready = 1'b1;
      S_A_START: begin
        cmd.lvl = found_lvl;
        raddr   = stat.head;
      end
      S_A_UNL: begin
        cmd.dec = 1'b1;
        if (stat.head == stat.tail) begin
          cmd.clr_full = 1'b1;
        end else begin
          cmd.wr_head  = 1'b1;
          cmd.head_val = d.nxt;
        end
      end
      S_A_LOOP: raddr = node;
      S_A_FIN: begin
        we          = 1'b1;
        wword.ord   = req;
        wword.used  = 1'b1;
        wword.fhead = 1'b0;
      end
      S_F_START: raddr = pfn_off[IDX_W-1:0];
      S_F_HEAD: begin
        we         = !head_bad && d.used;
        wword.used = 1'b0;
      end
      S_F_CHK: raddr = chk_stop ? node : bud;
      S_F_BUD: begin
        raddr = node;
        if (bud_match) begin
          we          = 1'b1;
          waddr       = bud;
          wword.fhead = 1'b0;
          cmd.dec     = 1'b1;
          if (stat.full) begin
            if (stat.head == bud && stat.tail == bud) begin
              cmd.clr_full = 1'b1;
            end else if (stat.head == bud) begin
              cmd.wr_head  = 1'b1;
              cmd.head_val = d.nxt;
            end else if (stat.tail == bud) begin
              cmd.wr_tail  = 1'b1;
              cmd.tail_val = d.prv;
            end
          end
        end
      end
      S_U_PRD: raddr = aux;
      S_U_PWR: begin
        we        = 1'b1;
        waddr     = aux;
        wword.nxt = aux2;
        raddr     = aux2;
      end
      S_U_NWR: begin
        we        = 1'b1;
        waddr     = aux2;
        wword.prv = aux;
      end
      S_F_ORD_RD: raddr = node;
      S_F_ORD_WR: begin
        we        = 1'b1;
        wword.ord = lvl;
      end
      S_PU_WR: begin
        we           = 1'b1;
        wword.ord    = lvl;
        wword.used   = 1'b0;
        wword.fhead  = 1'b1;
        cmd.inc      = 1'b1;
        cmd.wr_tail  = 1'b1;
        cmd.tail_val = node;
        if (stat.full) begin
          wword.prv = stat.tail;
          raddr     = stat.tail;
        end else begin
          cmd.wr_head  = 1'b1;
          cmd.head_val = node;
          cmd.set_full = 1'b1;
        end
      end
      S_PU_TW: begin
        we        = 1'b1;
        waddr     = aux;
        wword.nxt = node;
      end
      S_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        act_q <= action;
        ord_q <= order;
        pfn_q <= pfn;
      end
      S_A_START: begin
        is_free  <= act_q;
        lvl      <= found_lvl;
        req      <= ord_q;
        node     <= stat.head;
        frame_q  <= '0;
        status_q <= (ord_q >= LVL_W'(MAX_ORDER)) ? ST_BAD_ORDER :
                    (found ? ST_OK : ST_NO_MEM);
      end
      S_A_LOOP: if (lvl > req) lvl <= lvl - 1'b1;
      S_A_FIN:  frame_q <= FRAME_W'(first_frame) + FRAME_W'(node);
      S_F_START: begin
        is_free  <= act_q;
        node     <= pfn_off[IDX_W-1:0];
        frame_q  <= '0;
        status_q <= in_range ? ST_OK : ST_RANGE;
      end
      S_F_HEAD: begin
        lvl <= d.ord;
        if (head_bad) status_q <= ST_RANGE;
      end
      S_F_BUD: begin
        aux  <= d.prv;
        aux2 <= d.nxt;
        if (bud_match) begin
          lvl  <= lvl_up;
          node <= node & ~up_mask;
        end
      end
      S_PU_WR: begin
        aux <= stat.tail;
        if (!is_free && !stat.full) node <= node + (idx_t'(1) << lvl);
      end
      S_PU_TW: if (!is_free) node <= node + (idx_t'(1) << lvl);
      default: ;
    endcase
  end

  assign status     = status_q;
  assign frame      = frame_q;
  assign free_pages = stat.free_pages;

endmodule

// ===== design/bpa_page_ram.sv =====
// single-port-write, single-port-read page memory with registered read data
module bpa_page_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 30
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/bpa_free_lists.sv =====
// per-order list heads, tails, block counts and running free page total
module bpa_free_lists (
  input  logic                clk,
  input  logic                rst,
  input  bpa_pkg::lst_cmd_t   cmd,
  output bpa_pkg::lst_stat_t  stat
);
  import bpa_pkg::*;

  idx_t                 head [MAX_ORDER];
  idx_t                 tail [MAX_ORDER];
  logic [MAX_ORDER-1:0] full;
  logic [CNT_W-1:0]     cnt  [MAX_ORDER];
  logic [TOT_W-1:0]     total;
  logic [TOT_W-1:0]     unit;
  logic [TOT_W-1:0]     wrapv;
  logic [CNT_W-1:0]     cnt_cur;

  assign cnt_cur = cnt[cmd.lvl];
  assign unit    = TOT_W'(1) << cmd.lvl;
  assign wrapv   = TOT_W'({CNT_W{1'b1}}) << cmd.lvl;

  always_ff @(posedge clk) begin
    if (rst) begin
      full  <= '0;
      total <= '0;
      for (int o = 0; o < MAX_ORDER; o++) begin
        cnt[o] <= '0;
      end
    end else begin
      // counts wrap at their width, so the total follows the wrap
      if (cmd.inc) begin
        cnt[cmd.lvl] <= cnt_cur + 1'b1;
        total <= (cnt_cur == {CNT_W{1'b1}}) ? total - wrapv : total + unit;
      end else if (cmd.dec) begin
        cnt[cmd.lvl] <= cnt_cur - 1'b1;
        total <= (cnt_cur == '0) ? total + wrapv : total - unit;
      end
      if (cmd.set_full) begin
        full[cmd.lvl] <= 1'b1;
      end else if (cmd.clr_full) begin
        full[cmd.lvl] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_head) begin
      head[cmd.lvl] <= cmd.head_val;
    end
    if (cmd.wr_tail) begin
      tail[cmd.lvl] <= cmd.tail_val;
    end
  end

  always_comb begin
    stat.head       = head[cmd.lvl];
    stat.tail       = tail[cmd.lvl];
    stat.full       = full[cmd.lvl];
    stat.full_mask  = full;
    stat.free_pages = (total > TOT_W'({CNT_W{1'b1}})) ? {CNT_W{1'b1}} : total[CNT_W-1:0];
  end

endmodule

// ===== bench/tb.sv =====
// self-checking testbench for the buddy page allocator
module tb;
  import bpa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 1000000;
  localparam int HOLD_LEN = 400;

  typedef struct {
    status_t     st;
    logic [20:0] fr;
    logic [12:0] fp;
  } alloc_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        action = 1'b0;
  logic [3:0]  order = '0;
  logic [19:0] pfn = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [20:0] frame;
  logic [12:0] free_pages;

  buddy_page_allocator uut (.*);

  always #2 clk = ~clk;

  // shadow allocator state
  logic [3:0]       ord_mem  [NUM_PAGES];
  bit               in_use   [NUM_PAGES];
  bit               head_flg [NUM_PAGES];
  bit [IDX_W-1:0]   nxt_lnk  [NUM_PAGES];
  bit [IDX_W-1:0]   prv_lnk  [NUM_PAGES];
  bit [IDX_W-1:0]   fl_head  [MAX_ORDER];
  bit [IDX_W-1:0]   fl_tail  [MAX_ORDER];
  bit               fl_busy  [MAX_ORDER];
  bit [CNT_W-1:0]   fl_count [MAX_ORDER];
  bit [19:0]        cfg_start;
  bit [12:0]        cfg_count;

  alloc_result_t pending_q[$];
  int            held_q[$];
  alloc_result_t exp_r;
  int            errors = 0;
  int            cycles = 0;
  int            hold_cycles = 0;
  bit            hold_go = 1'b0;
  bit            hold_done = 1'b0;
  bit            src_idle_en = 1'b1;
  bit            snk_idle_en = 1'b1;

  task automatic report(input string msg);
    errors++;
    if (errors < 60) $display("tb: mismatch at %0t: %s", $realtime, msg);
  endtask

  function automatic int page_lim();
    return (cfg_count < NUM_PAGES) ? int'(cfg_count) : NUM_PAGES;
  endfunction

  function automatic void list_push(int o, int i);
    if (fl_busy[o]) begin
      nxt_lnk[fl_tail[o]] = IDX_W'(i);
      prv_lnk[i] = fl_tail[o];
    end else begin
      fl_head[o] = IDX_W'(i);
      fl_busy[o] = 1'b1;
    end
    fl_tail[o] = IDX_W'(i);
    head_flg[i] = 1'b1;
    in_use[i] = 1'b0;
    fl_count[o] = fl_count[o] + 1'b1;
  endfunction

  function automatic void list_unlink(int o, int i);
    bit [IDX_W-1:0] n, p;
    n = nxt_lnk[i];
    p = prv_lnk[i];
    if (fl_busy[o]) begin
      if (fl_head[o] == i && fl_tail[o] == i) fl_busy[o] = 1'b0;
      else if (fl_head[o] == i) fl_head[o] = n;
      else if (fl_tail[o] == i) fl_tail[o] = p;
      else begin
        nxt_lnk[p] = n;
        prv_lnk[n] = p;
      end
    end
    head_flg[i] = 1'b0;
    fl_count[o] = fl_count[o] - 1'b1;
  endfunction

  function automatic logic [12:0] pool_pages();
    longint sum;
    sum = 0;
    for (int o = 0; o < MAX_ORDER; o++) sum += longint'(fl_count[o]) << o;
    return (sum > 8191) ? 13'd8191 : 13'(sum);
  endfunction

  function automatic status_t take_block(int req, output logic [20:0] fr);
    int cur, i;
    fr = '0;
    if (req >= MAX_ORDER) return ST_BAD_ORDER;
    cur = req;
    while (cur < MAX_ORDER && !fl_busy[cur]) cur++;
    if (cur >= MAX_ORDER) return ST_NO_MEM;
    i = fl_head[cur];
    list_unlink(cur, i);
    // lower halves go back to the lists, the top piece is kept
    while (cur > req) begin
      cur--;
      ord_mem[i] = 4'(cur);
      list_push(cur, i);
      i = (i + (1 << cur)) % NUM_PAGES;
      ord_mem[i] = 4'(cur);
    end
    ord_mem[i] = 4'(req);
    in_use[i] = 1'b1;
    head_flg[i] = 1'b0;
    fr = 21'(cfg_start + i);
    held_q.push_back(i);
    return ST_OK;
  endfunction

  function automatic status_t give_block(logic [19:0] p);
    int lim, idx, o, bud;
    lim = page_lim();
    if (p < cfg_start) return ST_RANGE;
    idx = p - cfg_start;
    if (idx >= lim) return ST_RANGE;
    o = ord_mem[idx];
    if (o >= MAX_ORDER) return ST_RANGE;
    if ((idx & ((1 << o) - 1)) != 0) return ST_RANGE;
    if (!in_use[idx]) return ST_OK;
    in_use[idx] = 1'b0;
    forever begin
      ord_mem[idx] = 4'(o);
      if (o >= MAX_ORDER - 1) break;
      bud = idx ^ (1 << o);
      if (bud >= lim) break;
      if (ord_mem[bud] != o || !head_flg[bud]) break;
      list_unlink(o, bud);
      o++;
      idx &= ~((1 << o) - 1);
    end
    list_push(o, idx);
    return ST_OK;
  endfunction

  function automatic alloc_result_t predict_result(logic a, logic [3:0] o, logic [19:0] p);
    alloc_result_t r;
    r.fr = '0;
    if (a == 1'b0) r.st = take_block(o, r.fr);
    else r.st = give_block(p);
    if (r.st != ST_OK) r.fr = '0;
    r.fp = pool_pages();
    return r;
  endfunction

  function automatic void shadow_reset();
    for (int i = 0; i < NUM_PAGES; i++) begin
      ord_mem[i] = '0;
      in_use[i] = 1'b1;
      head_flg[i] = 1'b0;
      nxt_lnk[i] = '0;
      prv_lnk[i] = '0;
    end
    for (int o = 0; o < MAX_ORDER; o++) begin
      fl_head[o] = '0;
      fl_tail[o] = '0;
      fl_busy[o] = 1'b0;
      fl_count[o] = '0;
    end
    cfg_start = '0;
    cfg_count = 13'd4096;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // result receiver, with random stalls and one long hold-off counted here
  always @(negedge clk) begin
    if (hold_go && !hold_done) begin
      out_ready = 1'b0;
      hold_cycles++;
      if (hold_cycles >= HOLD_LEN) hold_done = 1'b1;
    end else begin
      out_ready = !snk_idle_en || ($urandom_range(99) >= 15);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        report("result transfer with nothing expected");
      end else begin
        exp_r = pending_q.pop_front();
        if (status !== exp_r.st)
          report($sformatf("status %0d, expected %0d", status, exp_r.st));
        if (frame !== exp_r.fr)
          report($sformatf("frame %0h, expected %0h", frame, exp_r.fr));
        if (free_pages !== exp_r.fp)
          report($sformatf("free_pages %0d, expected %0d", free_pages, exp_r.fp));
      end
    end
  end

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_item(input logic a, input logic [3:0] o, input logic [19:0] p);
    if (src_idle_en && $urandom_range(99) < 15) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid = 1'b1;
    action = a;
    order = o;
    pfn = p;
    do @(posedge clk); while (!in_ready);
    pending_q.push_back(predict_result(a, o, p));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic set_reg(input reg_idx_t r, input logic [31:0] v);
    logic [31:0] want;
    want = (r == REG_FIRST_FRAME) ? (v & 32'hFFFFF) : (v & 32'h1FFF);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {r[0], 2'b00};
    pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (r == REG_FIRST_FRAME) cfg_start = want[19:0];
    else cfg_count = want[12:0];
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      report($sformatf("register %0d reads %0h, expected %0h", r, prdata, want));
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic run_random(input int n);
    int r, span, j;
    logic [19:0] p;
    logic [3:0] o;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 40) begin
        o = ($urandom_range(99) < 85) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
        send_item(1'b0, o, 20'($urandom));
      end else if (r < 60 && held_q.size() != 0) begin
        j = $urandom_range(0, held_q.size() - 1);
        p = 20'(cfg_start + held_q[j]);
        held_q.delete(j);
        send_item(1'b1, 4'($urandom), p);
      end else if (r < 88) begin
        span = (page_lim() > 1024) ? 1024 : page_lim();
        send_item(1'b1, 4'($urandom), 20'(cfg_start + $urandom_range(0, span)));
      end else begin
        send_item(1'($urandom), 4'($urandom), 20'($urandom));
      end
    end
    drain();
  endtask

  task automatic test_directed_cases();
    send_item(1'b0, 4'd0, 20'd0);        // empty pool
    send_item(1'b0, 4'd11, 20'd0);       // order too large
    send_item(1'b0, 4'd15, 20'hFFFFF);
    send_item(1'b1, 4'd0, 20'd4096);     // beyond the page limit
    send_item(1'b1, 4'd15, 20'hFFFFF);
    send_item(1'b1, 4'd0, 20'd0);
    send_item(1'b1, 4'd0, 20'd1);        // merges with page 0
    send_item(1'b1, 4'd0, 20'd0);        // already free
    send_item(1'b1, 4'd0, 20'd3);
    send_item(1'b1, 4'd0, 20'd2);        // two merge levels
    send_item(1'b0, 4'd0, 20'd0);        // split down from order 2
    send_item(1'b0, 4'd1, 20'd0);
    send_item(1'b1, 4'd0, 20'd1);
    send_item(1'b1, 4'd0, 20'd2);
    send_item(1'b1, 4'd0, 20'd3);
    for (int i = 8; i < 16; i++) send_item(1'b1, 4'd0, 20'(i));
    send_item(1'b0, 4'd3, 20'd0);
    send_item(1'b1, 4'd0, 20'd9);        // inside an allocated block
    drain();
  endtask

  task automatic test_small_pool();
    set_reg(REG_PAGE_COUNT, 32'd64);
    run_random(250);
  endtask

  task automatic test_single_page();
    set_reg(REG_FIRST_FRAME, 32'h12345);
    set_reg(REG_PAGE_COUNT, 32'd1);
    run_random(60);
  endtask

  task automatic test_offset_pool();
    // upper register bits are dropped
    set_reg(REG_FIRST_FRAME, 32'hFFF00800);
    set_reg(REG_PAGE_COUNT, 32'hFFFF0200);
    run_random(400);
  endtask

  task automatic test_full_pool();
    set_reg(REG_FIRST_FRAME, 32'd0);
    set_reg(REG_PAGE_COUNT, 32'd4096);
    run_random(400);
  endtask

  task automatic test_top_frames();
    set_reg(REG_FIRST_FRAME, 32'hFFFFF);
    set_reg(REG_PAGE_COUNT, 32'd8191);
    run_random(60);
  endtask

  task automatic test_zero_limit();
    set_reg(REG_FIRST_FRAME, 32'd0);
    set_reg(REG_PAGE_COUNT, 32'd0);
    run_random(30);
  endtask

  task automatic test_backpressure();
    set_reg(REG_PAGE_COUNT, 32'd256);
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    hold_go = 1'b1;
    run_random(150);
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
  endtask

  initial begin
    shadow_reset();
    repeat (6) @(negedge clk);
    rst = 1'b0;
    test_directed_cases();
    test_small_pool();
    test_single_page();
    test_offset_pool();
    test_full_pool();
    test_top_frames();
    test_zero_limit();
    test_backpressure();
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
